// ----- rtl/core/utf8bc_pkg.sv -----
// Shared constants and types for the UTF-8 decoder with bidi classification.
`timescale 1ns / 1ps

package utf8bc_pkg;

    localparam int CP_W = 21;
    localparam int OFFSET_W = 10;

    localparam logic [3:0] CLS_L   = 4'd0;
    localparam logic [3:0] CLS_R   = 4'd1;
    localparam logic [3:0] CLS_AL  = 4'd2;
    localparam logic [3:0] CLS_EN  = 4'd3;
    localparam logic [3:0] CLS_AN  = 4'd6;
    localparam logic [3:0] CLS_NSM = 4'd8;
    localparam logic [3:0] CLS_B   = 4'd10;
    localparam logic [3:0] CLS_WS  = 4'd12;
    localparam logic [3:0] CLS_ON  = 4'd13;

    localparam logic [1:0] QDIR_LTR     = 2'd0;
    localparam logic [1:0] QDIR_RTL     = 2'd1;
    localparam logic [1:0] QDIR_MIXED   = 2'd2;
    localparam logic [1:0] QDIR_NEUTRAL = 2'd3;

    localparam logic [CP_W-1:0]     REPLACEMENT_CP   = 21'h00FFFD;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX       = 10'd1023;
    localparam logic [OFFSET_W-1:0] SCAN_LIMIT_RESET = 10'd100;

    typedef struct packed {
        logic [3:0]      cls;
        logic            is_mirrored;
        logic [CP_W-1:0] mirror_code;
    } class_info_t;

endpackage

// ----- rtl/core/utf8bc_classify.sv -----
// Bidi class and mirror lookup (brackets and quotation marks) for one code point.
`timescale 1ns / 1ps

module utf8bc_classify
    import utf8bc_pkg::*;
(
    input  logic [CP_W-1:0] cp,
    output class_info_t     info
);

    logic [3:0]      cls;
    logic [CP_W-1:0] mir;

    always_comb
    begin
        if (cp inside {[21'h000600:21'h0006FF]})
        begin
            if (cp inside {[21'h000660:21'h000669]})
                cls = CLS_AN;
            else if (cp inside {[21'h0006F0:21'h0006F9]})
                cls = CLS_EN;
            else if (cp inside {[21'h00064B:21'h00065F]} || cp == 21'h000670)
                cls = CLS_NSM;
            else
                cls = CLS_AL;
        end
        else if (cp inside {[21'h000750:21'h00077F], [21'h0008A0:21'h0008FF],
                            [21'h00FB50:21'h00FDFF], [21'h00FE70:21'h00FEFF]})
        begin
            cls = CLS_AL;
        end
        else if (cp < 21'h000080)
        begin
            if (cp inside {[21'h41:21'h5A], [21'h61:21'h7A]})
                cls = CLS_L;
            else if (cp inside {[21'h30:21'h39]})
                cls = CLS_EN;
            else if (cp == 21'h20)
                cls = CLS_WS;
            else if (cp == 21'h0A || cp == 21'h0D)
                cls = CLS_B;
            else
                cls = CLS_ON;
        end
        else if (cp inside {[21'h000590:21'h0005FF]})
        begin
            if (cp inside {[21'h000591:21'h0005BD]})
                cls = CLS_NSM;
            else
                cls = CLS_R;
        end
        else
        begin
            cls = CLS_L;
        end
    end

    always_comb
    begin
        case (cp)
            21'h28:   mir = 21'h29;
            21'h29:   mir = 21'h28;
            21'h5B:   mir = 21'h5D;
            21'h5D:   mir = 21'h5B;
            21'h7B:   mir = 21'h7D;
            21'h7D:   mir = 21'h7B;
            21'h3C:   mir = 21'h3E;
            21'h3E:   mir = 21'h3C;
            21'hAB:   mir = 21'hBB;
            21'hBB:   mir = 21'hAB;
            21'h2018: mir = 21'h2019;
            21'h2019: mir = 21'h2018;
            21'h201C: mir = 21'h201D;
            21'h201D: mir = 21'h201C;
            21'h2039: mir = 21'h203A;
            21'h203A: mir = 21'h2039;
            default:  mir = cp;
        endcase
    end

    assign info.cls         = cls;
    assign info.mirror_code = mir;
    assign info.is_mirrored = (mir != cp);

endmodule

// ----- rtl/core/utf8_bidi_classifier_core.sv -----
// Streaming UTF-8 decoder with simplified bidi classification and text summary.
// A character's result passes the decode register (s1) and then the output register.
// One byte per cycle unless out_ready stalls; decode and classify stage: one register each.
// Continuation bytes that neither complete a character nor carry last_byte give no result.
// Reset (rst_n low, asynchronous) clears all text state and sets the scan limit to 100.
`timescale 1ns / 1ps

module utf8_bidi_classifier_core
    import utf8bc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [OFFSET_W-1:0] scan_limit_bytes,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                last_byte,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [CP_W-1:0]     code_point,
    output logic [3:0]          bidi_class,
    output logic                is_mirrored,
    output logic [CP_W-1:0]     mirror_code,
    output logic                text_end,
    output logic                base_rtl,
    output logic [1:0]          quick_direction,
    output logic                has_arabic
);

    // Configuration and decode state.
    logic [OFFSET_W-1:0] scan_limit_reg;
    logic [1:0]          bytes_left_reg, bytes_left_next, left_dec;
    logic [CP_W-1:0]     partial_reg, partial_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                win_reg, win_next;
    logic                emit;
    logic [CP_W-1:0]     dec_cp;

    // Decoded character waiting for classification.
    logic                s1_valid_reg;
    logic [CP_W-1:0]     s1_cp_reg;
    logic                s1_last_reg;
    logic                s1_win_reg;

    // Text summary.
    logic base_found_reg, base_found_next;
    logic base_rtl_reg, base_rtl_next;
    logic seen_rtl_reg, seen_rtl_next;
    logic seen_ltr_reg, seen_ltr_next;
    logic seen_arabic_reg, seen_arabic_next;

    logic        out_valid_reg;
    logic        in_fire;
    logic        out_adv;
    logic        s1_fire;
    class_info_t info;
    logic        strong_rtl, strong_ltr;
    logic [1:0]  qdir;

    assign cfg_ready = 1'b1;
    assign out_adv   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || out_adv;
    assign in_fire   = in_valid && in_ready;
    assign s1_fire   = s1_valid_reg && out_adv;
    assign out_valid = out_valid_reg;
    assign left_dec  = bytes_left_reg - 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_limit_reg <= SCAN_LIMIT_RESET;
        else if (cfg_valid && cfg_ready)
            scan_limit_reg <= scan_limit_bytes;
    end

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        partial_next    = partial_reg;
        offset_next     = offset_reg;
        win_next        = win_reg;
        emit            = 1'b0;
        dec_cp          = '0;
        if (in_fire)
        begin
            if (bytes_left_reg == 2'd0)
            begin
                win_next = (offset_reg < scan_limit_reg);
                case (in_byte) inside
                    8'b0???????:
                    begin
                        dec_cp = {13'd0, in_byte};
                        emit   = 1'b1;
                    end
                    8'b110?????:
                    begin
                        partial_next    = {10'd0, in_byte[4:0], 6'd0};
                        bytes_left_next = 2'd1;
                    end
                    8'b1110????:
                    begin
                        partial_next    = {5'd0, in_byte[3:0], 12'd0};
                        bytes_left_next = 2'd2;
                    end
                    8'b11110???:
                    begin
                        partial_next    = {in_byte[2:0], 18'd0};
                        bytes_left_next = 2'd3;
                    end
                    default:
                    begin
                        dec_cp = REPLACEMENT_CP;
                        emit   = 1'b1;
                    end
                endcase
            end
            else
            begin
                bytes_left_next = left_dec;
                case (left_dec)
                    2'd0:    partial_next = partial_reg | {15'd0, in_byte[5:0]};
                    2'd1:    partial_next = partial_reg | {9'd0, in_byte[5:0], 6'd0};
                    default: partial_next = partial_reg | {3'd0, in_byte[5:0], 12'd0};
                endcase
                if (left_dec == 2'd0)
                begin
                    dec_cp = partial_next;
                    emit   = 1'b1;
                end
            end
            // A sequence cut off by the end of text is emitted with zero fill.
            if (last_byte && !emit)
            begin
                dec_cp = partial_next;
                emit   = 1'b1;
            end
            if (offset_reg != OFFSET_MAX)
                offset_next = offset_reg + 10'd1;
            if (last_byte)
            begin
                bytes_left_next = 2'd0;
                partial_next    = '0;
                offset_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 2'd0;
            partial_reg    <= '0;
            offset_reg     <= '0;
            win_reg        <= 1'b0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            partial_reg    <= partial_next;
            offset_reg     <= offset_next;
            // The window flag of the last character is not needed past its transaction.
            win_reg        <= (in_fire && last_byte) ? 1'b0 : win_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_fire && emit;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            s1_cp_reg   <= dec_cp;
            s1_last_reg <= last_byte;
            s1_win_reg  <= win_next;
        end
    end

    utf8bc_classify u_classify
    (
        .cp   (s1_cp_reg),
        .info (info)
    );

    assign strong_rtl = (info.cls == CLS_R) || (info.cls == CLS_AL);
    assign strong_ltr = (info.cls == CLS_L);

    always_comb
    begin
        seen_arabic_next = seen_arabic_reg || (info.cls == CLS_AL);
        base_found_next  = base_found_reg;
        base_rtl_next    = base_rtl_reg;
        if (!base_found_reg && (strong_rtl || strong_ltr))
        begin
            base_found_next = 1'b1;
            base_rtl_next   = strong_rtl;
        end
        seen_rtl_next = seen_rtl_reg || (s1_win_reg && strong_rtl);
        seen_ltr_next = seen_ltr_reg || (s1_win_reg && strong_ltr);
        if (seen_rtl_next && seen_ltr_next)
            qdir = QDIR_MIXED;
        else if (seen_rtl_next)
            qdir = QDIR_RTL;
        else if (seen_ltr_next)
            qdir = QDIR_LTR;
        else
            qdir = QDIR_NEUTRAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_found_reg  <= 1'b0;
            base_rtl_reg    <= 1'b0;
            seen_rtl_reg    <= 1'b0;
            seen_ltr_reg    <= 1'b0;
            seen_arabic_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
            if (s1_fire)
            begin
                if (s1_last_reg)
                begin
                    base_found_reg  <= 1'b0;
                    base_rtl_reg    <= 1'b0;
                    seen_rtl_reg    <= 1'b0;
                    seen_ltr_reg    <= 1'b0;
                    seen_arabic_reg <= 1'b0;
                end
                else
                begin
                    base_found_reg  <= base_found_next;
                    base_rtl_reg    <= base_rtl_next;
                    seen_rtl_reg    <= seen_rtl_next;
                    seen_ltr_reg    <= seen_ltr_next;
                    seen_arabic_reg <= seen_arabic_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            code_point      <= s1_cp_reg;
            bidi_class      <= info.cls;
            is_mirrored     <= info.is_mirrored;
            mirror_code     <= info.mirror_code;
            text_end        <= s1_last_reg;
            base_rtl        <= s1_last_reg && base_found_next && base_rtl_next;
            quick_direction <= s1_last_reg ? qdir : QDIR_LTR;
            has_arabic      <= s1_last_reg && seen_arabic_next;
        end
    end

    // A final byte always closes the character and restarts the text.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_byte |=> bytes_left_reg == 2'd0 && offset_reg == '0)
        else $error("decode state not cleared after final byte");

    // A final byte always produces a result transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_byte |=> s1_valid_reg && s1_last_reg)
        else $error("final byte produced no result");

    // Summary fields are zero except on the transaction that closes a text.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !text_end |-> !base_rtl && quick_direction == QDIR_LTR && !has_arabic)
        else $error("summary fields set outside text end");

    // A decoded character held back by a stalled output keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_adv |=> s1_valid_reg && $stable(s1_cp_reg) && $stable(s1_last_reg))
        else $error("pending character lost while stalled");

    // The mirrored flag agrees with the mirror code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> is_mirrored == (mirror_code != code_point))
        else $error("mirror flag inconsistent");

endmodule

// ----- bench/utf8bc_result_checker.sv -----
// Checker that predicts and compares every result of the UTF-8 bidi classifier.
`timescale 1ns / 1ps

module utf8bc_result_checker
    import utf8bc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [OFFSET_W-1:0] scan_limit_bytes,

    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                last_byte,

    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [CP_W-1:0]     code_point,
    input  logic [3:0]          bidi_class,
    input  logic                is_mirrored,
    input  logic [CP_W-1:0]     mirror_code,
    input  logic                text_end,
    input  logic                base_rtl,
    input  logic [1:0]          quick_direction,
    input  logic                has_arabic,

    output int                  pending,
    output int                  fail_count
);

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic [3:0]      cls;
        logic            mirrored;
        logic [CP_W-1:0] mcode;
        logic            tend;
        logic            brtl;
        logic [1:0]      qdir;
        logic            arabic;
    } char_result_t;

    char_result_t expected_chars[$];
    char_result_t got;

    logic [OFFSET_W-1:0] limit_q;
    logic [OFFSET_W-1:0] offset_q;
    logic [1:0]          cont_left;
    logic [CP_W-1:0]     gathered;
    logic                lead_counts;
    logic                base_seen;
    logic                base_rtl_q;
    logic                rtl_seen;
    logic                ltr_seen;
    logic                arabic_seen;
    int                  errors;

    function automatic logic [3:0] bidi_class_of(input logic [CP_W-1:0] cp);
        if (cp >= 21'h000600 && cp <= 21'h0006FF)
        begin
            if (cp >= 21'h000660 && cp <= 21'h000669) return CLS_AN;
            if (cp >= 21'h0006F0 && cp <= 21'h0006F9) return CLS_EN;
            if (cp >= 21'h00064B && cp <= 21'h00065F) return CLS_NSM;
            if (cp == 21'h000670) return CLS_NSM;
            return CLS_AL;
        end
        if (cp >= 21'h000750 && cp <= 21'h00077F) return CLS_AL;
        if (cp >= 21'h0008A0 && cp <= 21'h0008FF) return CLS_AL;
        if (cp >= 21'h00FB50 && cp <= 21'h00FDFF) return CLS_AL;
        if (cp >= 21'h00FE70 && cp <= 21'h00FEFF) return CLS_AL;
        if (cp < 21'h000080)
        begin
            if (cp >= 21'h41 && cp <= 21'h5A) return CLS_L;
            if (cp >= 21'h61 && cp <= 21'h7A) return CLS_L;
            if (cp >= 21'h30 && cp <= 21'h39) return CLS_EN;
            if (cp == 21'h20) return CLS_WS;
            if (cp == 21'h0A || cp == 21'h0D) return CLS_B;
            return CLS_ON;
        end
        if (cp >= 21'h000590 && cp <= 21'h0005FF)
        begin
            if (cp >= 21'h000591 && cp <= 21'h0005BD) return CLS_NSM;
            return CLS_R;
        end
        return CLS_L;
    endfunction

    function automatic logic [CP_W-1:0] mirror_partner(input logic [CP_W-1:0] cp);
        case (cp)
            21'h28:     return 21'h29;
            21'h29:     return 21'h28;
            21'h5B:     return 21'h5D;
            21'h5D:     return 21'h5B;
            21'h7B:     return 21'h7D;
            21'h7D:     return 21'h7B;
            21'h3C:     return 21'h3E;
            21'h3E:     return 21'h3C;
            21'hAB:     return 21'hBB;
            21'hBB:     return 21'hAB;
            21'h2018:   return 21'h2019;
            21'h2019:   return 21'h2018;
            21'h201C:   return 21'h201D;
            21'h201D:   return 21'h201C;
            21'h2039:   return 21'h203A;
            21'h203A:   return 21'h2039;
            default:    return cp;
        endcase
    endfunction

    task automatic clear_text_state();
        cont_left   = '0;
        gathered    = '0;
        offset_q    = '0;
        lead_counts = 1'b0;
        base_seen   = 1'b0;
        base_rtl_q  = 1'b0;
        rtl_seen    = 1'b0;
        ltr_seen    = 1'b0;
        arabic_seen = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic            emit;
        logic [CP_W-1:0] cp;
        char_result_t    r;
        logic            strong_rtl;
        logic            strong_ltr;
        emit = 1'b0;
        cp   = '0;
        if (cont_left == 2'd0)
        begin
            // The window decision is taken at the lead byte and held for the character.
            lead_counts = offset_q < limit_q;
            if (!b[7])
            begin
                cp   = {13'd0, b};
                emit = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                gathered  = {10'd0, b[4:0], 6'd0};
                cont_left = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                gathered  = {5'd0, b[3:0], 12'd0};
                cont_left = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                gathered  = {b[2:0], 18'd0};
                cont_left = 2'd3;
            end
            else
            begin
                cp   = REPLACEMENT_CP;
                emit = 1'b1;
            end
        end
        else
        begin
            cont_left = cont_left - 2'd1;
            gathered  = gathered | ({15'd0, b[5:0]} << (6 * cont_left));
            if (cont_left == 2'd0)
            begin
                cp   = gathered;
                emit = 1'b1;
            end
        end
        // A text that stops inside a character flushes what has been gathered.
        if (last && !emit)
        begin
            cp   = gathered;
            emit = 1'b1;
        end
        if (offset_q != OFFSET_MAX)
            offset_q = offset_q + 10'd1;
        if (emit)
        begin
            r.cp       = cp;
            r.cls      = bidi_class_of(cp);
            r.mcode    = mirror_partner(cp);
            r.mirrored = r.mcode != cp;
            r.tend     = last;
            r.brtl     = 1'b0;
            r.qdir     = QDIR_LTR;
            r.arabic   = 1'b0;
            strong_rtl = (r.cls == CLS_R) || (r.cls == CLS_AL);
            strong_ltr = r.cls == CLS_L;
            if (r.cls == CLS_AL)
                arabic_seen = 1'b1;
            if (!base_seen && (strong_rtl || strong_ltr))
            begin
                base_seen  = 1'b1;
                base_rtl_q = strong_rtl;
            end
            if (lead_counts)
            begin
                if (strong_rtl)
                    rtl_seen = 1'b1;
                if (strong_ltr)
                    ltr_seen = 1'b1;
            end
            if (last)
            begin
                r.brtl = base_seen && base_rtl_q;
                if (rtl_seen && ltr_seen)
                    r.qdir = QDIR_MIXED;
                else if (rtl_seen)
                    r.qdir = QDIR_RTL;
                else if (ltr_seen)
                    r.qdir = QDIR_LTR;
                else
                    r.qdir = QDIR_NEUTRAL;
                r.arabic = arabic_seen;
                clear_text_state();
            end
            expected_chars.insert(expected_chars.size(), r);
        end
    endtask

    task automatic check_field(input string name, input logic [CP_W-1:0] exp_val,
                               input logic [CP_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_q = SCAN_LIMIT_RESET;
            clear_text_state();
            expected_chars.delete();
            errors = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected result transaction, expected none, actual %0h",
                             $time, code_point);
                end
                else
                begin
                    got = expected_chars.pop_front();
                    check_field("code_point", got.cp, code_point);
                    check_field("bidi_class", CP_W'(got.cls), CP_W'(bidi_class));
                    check_field("is_mirrored", CP_W'(got.mirrored), CP_W'(is_mirrored));
                    check_field("mirror_code", got.mcode, mirror_code);
                    check_field("text_end", CP_W'(got.tend), CP_W'(text_end));
                    check_field("base_rtl", CP_W'(got.brtl), CP_W'(base_rtl));
                    check_field("quick_direction", CP_W'(got.qdir), CP_W'(quick_direction));
                    check_field("has_arabic", CP_W'(got.arabic), CP_W'(has_arabic));
                end
            end
            // A byte taken at the same edge as a limit write still sees the old limit.
            if (in_valid && in_ready)
                decode_byte(in_byte, last_byte);
            if (cfg_valid && cfg_ready)
                limit_q = scan_limit_bytes;
            pending    <= expected_chars.size();
            fail_count <= errors;
        end
    end

endmodule

// ----- bench/tb_utf8_bidi_classifier_core.sv -----
// Top-level testbench: drives text bytes and scan limits into the classifier and gives the verdict.
`timescale 1ns / 1ps

module tb_utf8_bidi_classifier_core
    import utf8bc_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_BYTES = 4;
    localparam int NUM_PHASES  = 10;

    localparam logic [CP_W-1:0] MIRROR_SET [19] = '{
        21'h28, 21'h29, 21'h5B, 21'h5D, 21'h7B, 21'h7D, 21'h3C, 21'h3E,
        21'hAB, 21'hBB, 21'h2018, 21'h2019, 21'h201C, 21'h201D, 21'h2039,
        21'h203A, 21'h2017, 21'h201A, 21'h203B
    };

    localparam logic [CP_W-1:0] RANGE_BOUNDS [36] = '{
        21'h05FF, 21'h0600, 21'h06FF, 21'h0700, 21'h065F, 21'h0660, 21'h0669,
        21'h066A, 21'h06F0, 21'h06F9, 21'h0670, 21'h064A, 21'h05BD, 21'h05BE,
        21'h0591, 21'h0590, 21'h074F, 21'h0780, 21'h089F, 21'h0900, 21'hFB4F,
        21'hFE00, 21'hFE6F, 21'hFF00, 21'h0040, 21'h005B, 21'h0060, 21'h007B,
        21'h002F, 21'h003A, 21'h001F, 21'h0021, 21'h0009, 21'h000B, 21'h000C,
        21'h000E
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [OFFSET_W-1:0] scan_limit_bytes;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          in_byte;
    logic                last_byte;
    logic                out_valid;
    logic                out_ready;
    logic [CP_W-1:0]     code_point;
    logic [3:0]          bidi_class;
    logic                is_mirrored;
    logic [CP_W-1:0]     mirror_code;
    logic                text_end;
    logic                base_rtl;
    logic [1:0]          quick_direction;
    logic                has_arabic;

    int                  pending_chars;
    int                  fail_count;
    int                  cycle_count;
    int                  hold_requests;
    int                  holds_served = 0;
    logic                idle_on;
    logic [7:0]          text_buf[$];
    int                  last_char_len;

    utf8_bidi_classifier_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .scan_limit_bytes (scan_limit_bytes),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_byte          (in_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .code_point       (code_point),
        .bidi_class       (bidi_class),
        .is_mirrored      (is_mirrored),
        .mirror_code      (mirror_code),
        .text_end         (text_end),
        .base_rtl         (base_rtl),
        .quick_direction  (quick_direction),
        .has_arabic       (has_arabic)
    );

    utf8bc_result_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .scan_limit_bytes (scan_limit_bytes),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_byte          (in_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .code_point       (code_point),
        .bidi_class       (bidi_class),
        .is_mirrored      (is_mirrored),
        .mirror_code      (mirror_code),
        .text_end         (text_end),
        .base_rtl         (base_rtl),
        .quick_direction  (quick_direction),
        .has_arabic       (has_arabic),
        .pending          (pending_chars),
        .fail_count       (fail_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off when the stimulus asks.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic logic [CP_W-1:0] pick_code_point();
        logic [CP_W-1:0] cp;
        case ($urandom_range(0, 11))
            0:       cp = CP_W'($urandom_range(0, 127));
            1:       cp = CP_W'($urandom_range(0, 1) ? $urandom_range('h41, 'h5A)
                                                     : $urandom_range('h61, 'h7A));
            2:       cp = CP_W'($urandom_range('h600, 'h6FF));
            3:       cp = CP_W'($urandom_range('h590, 'h5FF));
            4:       cp = CP_W'($urandom_range(0, 1) ? $urandom_range('h750, 'h77F)
                                                     : $urandom_range('h8A0, 'h8FF));
            5:       cp = CP_W'($urandom_range(0, 1) ? $urandom_range('hFB50, 'hFDFF)
                                                     : $urandom_range('hFE70, 'hFEFF));
            6:       cp = MIRROR_SET[$urandom_range(0, 18)];
            7:       cp = CP_W'($urandom_range('h80, 'h7FF));
            8:       cp = CP_W'($urandom_range('h800, 'hFFFF));
            9:       cp = CP_W'($urandom_range('h10000, 'h1FFFFF));
            default: cp = RANGE_BOUNDS[$urandom_range(0, 35)];
        endcase
        return cp;
    endfunction

    task automatic queue_byte(input logic [7:0] value);
        text_buf.insert(text_buf.size(), value);
    endtask

    task automatic append_char(input logic [CP_W-1:0] cp);
        if (cp < 21'h80)
        begin
            queue_byte(cp[7:0]);
            last_char_len = 1;
        end
        else if (cp < 21'h800)
        begin
            queue_byte({3'b110, cp[10:6]});
            queue_byte({2'b10, cp[5:0]});
            last_char_len = 2;
        end
        else if (cp < 21'h10000)
        begin
            queue_byte({4'b1110, cp[15:12]});
            queue_byte({2'b10, cp[11:6]});
            queue_byte({2'b10, cp[5:0]});
            last_char_len = 3;
        end
        else
        begin
            queue_byte({5'b11110, cp[20:18]});
            queue_byte({2'b10, cp[17:12]});
            queue_byte({2'b10, cp[11:6]});
            queue_byte({2'b10, cp[5:0]});
            last_char_len = 4;
        end
    endtask

    // Mostly well-formed characters; noisy texts also carry raw bytes, bad leads
    // and characters that lose their tail to the next lead byte.
    task automatic build_text(input int nchars, input bit clean);
        int kind;
        text_buf.delete();
        repeat (nchars)
        begin
            kind = clean ? 0 : $urandom_range(0, 19);
            if (kind == 17 || kind == 18)
            begin
                queue_byte(8'($urandom_range(0, 255)));
                last_char_len = 1;
            end
            else if (kind == 19)
            begin
                queue_byte(8'($urandom_range(0, 1) ? 32'h80 | $urandom_range(0, 63)
                                                   : 32'hF8 | $urandom_range(0, 7)));
                last_char_len = 1;
            end
            else if (kind == 16)
            begin
                append_char(CP_W'($urandom_range('h80, 'h1FFFFF)));
                repeat ($urandom_range(1, last_char_len - 1)) void'(text_buf.pop_back());
                last_char_len = 1;
            end
            else
                append_char(pick_code_point());
        end
        if (last_char_len > 1 && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, last_char_len - 1)) void'(text_buf.pop_back());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        last_byte <= last;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_text(input logic ends_text);
        foreach (text_buf[i])
            send_byte(text_buf[i], ends_text && (i == text_buf.size() - 1));
    endtask

    task automatic run_phase(input int nbytes, input bit allow_open);
        int sent;
        bit ends_text;
        sent = 0;
        while (sent < nbytes)
        begin
            build_text($urandom_range(1, 6), $urandom_range(0, 2) == 0);
            sent += text_buf.size();
            // Sometimes the phase stops mid-text so the next limit lands inside a text.
            ends_text = !(allow_open && sent >= nbytes && $urandom_range(0, 2) == 0);
            send_text(ends_text);
        end
        in_valid <= 1'b0;
    endtask

    // Waits until every expected result has come, then lets a character without
    // a result finish its way through the pipeline.
    task automatic wait_drained();
        do @(posedge clk); while (pending_chars != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [OFFSET_W-1:0] value);
        cfg_valid        <= 1'b1;
        scan_limit_bytes <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [OFFSET_W-1:0] phase_limits [NUM_PHASES];
        logic [7:0]          b;
        phase_limits = '{10'd0, OFFSET_MAX, 10'd1, 10'($urandom_range(2, 40)),
                         10'($urandom_range(0, 1023)), 10'd12, 10'($urandom_range(0, 30)),
                         10'd1022, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 60))};
        rst_n            <= 1'b0;
        cfg_valid        <= 1'b0;
        scan_limit_bytes <= '0;
        in_valid         <= 1'b0;
        in_byte          <= '0;
        last_byte        <= 1'b0;
        idle_on          <= 1'b1;
        hold_requests    <= 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Letters, Arabic, Hebrew, a bracket, a curly quote, a bad lead and a
        // four-byte character, left open across a limit change.
        text_buf = '{8'h41, 8'hD8, 8'hA7, 8'hD7, 8'h90, 8'h28, 8'hE2, 8'h80, 8'h9C,
                     8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text(1'b0);
        in_valid <= 1'b0;
        wait_drained();
        write_limit(10'd3);
        // ASCII extremes, a top-range bad lead, an unchecked continuation and a
        // three-byte character cut off by the end of the text.
        text_buf = '{8'h00, 8'h7F, 8'hFF, 8'hC3, 8'h41, 8'hE2, 8'h80};
        send_text(1'b1);
        // A text that ends right on a four-byte lead.
        text_buf = '{8'hF0};
        send_text(1'b1);
        // Mark and space only: no strong direction at all.
        text_buf = '{8'hD9, 8'h8B, 8'h20};
        send_text(1'b1);
        in_valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            write_limit(phase_limits[p]);
            idle_on <= (p != 6) && (p != NUM_PHASES - 1);
            run_phase(PHASE_BYTES, p != NUM_PHASES - 1);
            if (p == 4)
            begin
                // One text long enough to saturate the offset: ASCII filler without letters up
                // to near the edge of the widest window, then random characters that run past it.
                // The receiver holds off meanwhile, so the block fills and stalls.
                wait_drained();
                write_limit(OFFSET_MAX);
                hold_requests <= hold_requests + 1;
                text_buf.delete();
                repeat (1021)
                begin
                    do b = 8'($urandom_range(0, 127));
                    while ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A));
                    queue_byte(b);
                end
                repeat (12) append_char(pick_code_point());
                send_text(1'b1);
                in_valid <= 1'b0;
            end
        end

        do @(posedge clk); while (pending_chars != 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_chars == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/utf8bc_pkg.sv
rtl/core/utf8bc_classify.sv
rtl/core/utf8_bidi_classifier_core.sv
bench/utf8bc_result_checker.sv
bench/tb_utf8_bidi_classifier_core.sv
